>>> design/rcpwm_pkg.sv
`timescale 1ns / 1ps

package rcpwm_pkg;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int BOUND_BITS    = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE       = 3'd0,
		REG_IN_LOW     = 3'd1,
		REG_IN_HIGH    = 3'd2,
		REG_OUT_MIN    = 3'd3,
		REG_OUT_MAX    = 3'd4,
		REG_DEAD_LOW   = 3'd5,
		REG_DEAD_HIGH  = 3'd6,
		REG_DEAD_VALUE = 3'd7
	} cfg_idx_t;

	localparam logic [1:0]            MODE_RESET    = 2'd0;
	localparam logic [BOUND_BITS-1:0] IN_LOW_RESET  = 16'd1000;
	localparam logic [BOUND_BITS-1:0] IN_HIGH_RESET = 16'd2000;
	localparam logic [BOUND_BITS-1:0] OUT_MIN_RESET = 16'd0;
	localparam logic [BOUND_BITS-1:0] OUT_MAX_RESET = 16'd255;
	localparam logic [BOUND_BITS-1:0] DEAD_RESET    = 16'd0;

	localparam int MODE_MAP_BIT  = 0;
	localparam int MODE_DEAD_BIT = 1;

	typedef struct packed {
		logic [1:0]                   mode;
		logic [BOUND_BITS-1:0]        in_low;
		logic [BOUND_BITS-1:0]        in_high;
		logic signed [BOUND_BITS-1:0] out_min;
		logic signed [BOUND_BITS-1:0] out_max;
		logic signed [BOUND_BITS-1:0] dead_low;
		logic signed [BOUND_BITS-1:0] dead_high;
		logic signed [BOUND_BITS-1:0] dead_value;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_MUL   = 3'd1,
		ST_SETUP = 3'd2,
		ST_DIV   = 3'd3,
		ST_FIX   = 3'd4,
		ST_DONE  = 3'd5
	} state_t;

	typedef struct packed {
		logic capture_rise;
		logic capture_fall;
		logic mul;
		logic setup;
		logic step;
		logic fix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic map_en;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> design/rcpwm_ifs.sv
`timescale 1ns / 1ps

interface rcpwm_edge_if #(
	parameter int TIMESTAMP_BITS = 32
);
	logic                      valid;
	logic                      ready;
	logic                      pin_level;
	logic [TIMESTAMP_BITS-1:0] timestamp_us;

	modport source (output valid, output pin_level, output timestamp_us, input ready);
	modport sink (input valid, input pin_level, input timestamp_us, output ready);
endinterface

interface rcpwm_result_if #(
	parameter int WIDTH_BITS = 16,
	parameter int VALUE_BITS = 17
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;
	logic [WIDTH_BITS-1:0]        pulse_width;
	logic                         width_saturated;

	modport source (output valid, output value, output pulse_width, output width_saturated,
		input ready);
	modport sink (input valid, input value, input pulse_width, input width_saturated,
		output ready);
endinterface

interface rcpwm_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [rcpwm_pkg::CFG_IDX_BITS-1:0]    index;
	logic [rcpwm_pkg::CFG_DATA_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/rcpwm_cfg.sv
`timescale 1ns / 1ps

module rcpwm_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	rcpwm_cfg_if.sink             cfg,
	output rcpwm_pkg::cfg_regs_t  regs
);

	rcpwm_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode       <= rcpwm_pkg::MODE_RESET;
			regs_q.in_low     <= rcpwm_pkg::IN_LOW_RESET;
			regs_q.in_high    <= rcpwm_pkg::IN_HIGH_RESET;
			regs_q.out_min    <= rcpwm_pkg::OUT_MIN_RESET;
			regs_q.out_max    <= rcpwm_pkg::OUT_MAX_RESET;
			regs_q.dead_low   <= rcpwm_pkg::DEAD_RESET;
			regs_q.dead_high  <= rcpwm_pkg::DEAD_RESET;
			regs_q.dead_value <= rcpwm_pkg::DEAD_RESET;
		end else if (cfg.valid) begin
			case (rcpwm_pkg::cfg_idx_t'(cfg.index))
				rcpwm_pkg::REG_MODE:       regs_q.mode       <= cfg.data[1:0];
				rcpwm_pkg::REG_IN_LOW:     regs_q.in_low     <= cfg.data;
				rcpwm_pkg::REG_IN_HIGH:    regs_q.in_high    <= cfg.data;
				rcpwm_pkg::REG_OUT_MIN:    regs_q.out_min    <= cfg.data;
				rcpwm_pkg::REG_OUT_MAX:    regs_q.out_max    <= cfg.data;
				rcpwm_pkg::REG_DEAD_LOW:   regs_q.dead_low   <= cfg.data;
				rcpwm_pkg::REG_DEAD_HIGH:  regs_q.dead_high  <= cfg.data;
				rcpwm_pkg::REG_DEAD_VALUE: regs_q.dead_value <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

>>> design/rcpwm_ctrl.sv
`timescale 1ns / 1ps

module rcpwm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_pin_level,
	output logic                 in_ready,
	input  rcpwm_pkg::status_t   status,
	output rcpwm_pkg::cmd_t      cmd
);

	rcpwm_pkg::state_t state_q;
	rcpwm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcpwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rcpwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_pin_level) begin
						cmd.capture_rise = 1'b1;
					end else begin
						cmd.capture_fall = 1'b1;
						state_d = status.map_en ? rcpwm_pkg::ST_MUL : rcpwm_pkg::ST_DONE;
					end
				end
			end
			rcpwm_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = rcpwm_pkg::ST_SETUP;
			end
			rcpwm_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = rcpwm_pkg::ST_DIV;
			end
			rcpwm_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_d = rcpwm_pkg::ST_FIX;
				end else begin
					cmd.step = 1'b1;
				end
			end
			rcpwm_pkg::ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = rcpwm_pkg::ST_DONE;
			end
			rcpwm_pkg::ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = rcpwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rcpwm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/rcpwm_dp.sv
`timescale 1ns / 1ps

module rcpwm_dp #(
	parameter int TIMESTAMP_BITS = 32,
	parameter int WIDTH_BITS     = 16,
	parameter int VALUE_BITS     = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [TIMESTAMP_BITS-1:0]  timestamp_us,
	input  rcpwm_pkg::cfg_regs_t       regs,
	input  rcpwm_pkg::cmd_t            cmd,
	output rcpwm_pkg::status_t         status,
	rcpwm_result_if.source             results
);

	localparam int BB  = rcpwm_pkg::BOUND_BITS;
	localparam int AW  = ((WIDTH_BITS > BB) ? WIDTH_BITS : BB) + 1;
	localparam int SW  = BB + 1;
	localparam int PW  = AW + SW;
	localparam int RW  = PW + 2;
	localparam int CW  = $clog2(PW + 1);

	logic [TIMESTAMP_BITS-1:0] rise_q;
	logic [WIDTH_BITS-1:0]     width_q;
	logic                      sat_q;
	logic [TIMESTAMP_BITS-1:0] diff;
	logic [WIDTH_BITS-1:0]     width_d;
	logic                      sat_d;

	logic signed [AW-1:0]      offset;
	logic signed [SW-1:0]      span;
	logic signed [SW-1:0]      den;
	logic                      den_zero;
	logic signed [PW-1:0]      prod_q;

	logic [PW-1:0]             quo_q;
	logic [BB-1:0]             rem_q;
	logic [BB-1:0]             dmag_q;
	logic                      neg_q;
	logic [CW-1:0]             cnt_q;
	logic [BB:0]               shifted;
	logic                      ge;

	logic signed [RW-1:0]      qsig;
	logic signed [RW-1:0]      sum;
	logic signed [BB-1:0]      clamped;
	logic signed [BB-1:0]      res_d;
	logic signed [BB-1:0]      res_q;

	logic                         out_valid_q;
	logic signed [VALUE_BITS-1:0] out_value_q;
	logic [WIDTH_BITS-1:0]        out_width_q;
	logic                         out_sat_q;

	assign diff = timestamp_us - rise_q;

	generate
		if (TIMESTAMP_BITS > WIDTH_BITS) begin : g_sat
			assign sat_d   = |diff[TIMESTAMP_BITS-1:WIDTH_BITS];
			assign width_d = sat_d ? '1 : diff[WIDTH_BITS-1:0];
		end else begin : g_nosat
			assign sat_d   = 1'b0;
			assign width_d = WIDTH_BITS'(diff);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q  <= '0;
			width_q <= '0;
			sat_q   <= 1'b0;
		end else if (cmd.capture_rise) begin
			rise_q <= timestamp_us;
		end else if (cmd.capture_fall) begin
			width_q <= width_d;
			sat_q   <= sat_d;
		end
	end

	assign offset   = $signed({1'b0, (AW-1)'(width_q)}) - $signed({1'b0, (AW-1)'(regs.in_low)});
	assign span     = SW'(regs.out_max) - SW'(regs.out_min);
	assign den      = $signed({1'b0, regs.in_high}) - $signed({1'b0, regs.in_low});
	assign den_zero = (regs.in_high == regs.in_low);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PW'(offset) * PW'(span);
		end
	end

	assign shifted = {rem_q, quo_q[PW-1]};
	assign ge      = (shifted >= {1'b0, dmag_q});

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			quo_q  <= prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
			dmag_q <= den[SW-1] ? BB'(-den) : BB'(den);
			neg_q  <= prod_q[PW-1] ^ den[SW-1];
			rem_q  <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[PW-2:0], ge};
			rem_q <= ge ? BB'(shifted - {1'b0, dmag_q}) : shifted[BB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.setup) begin
			cnt_q <= CW'(PW);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_comb begin
		if (den_zero) begin
			qsig = '0;
		end else if (neg_q) begin
			qsig = -$signed({2'b00, quo_q});
		end else begin
			qsig = $signed({2'b00, quo_q});
		end
		sum = qsig + RW'(regs.out_min);
		if (sum < RW'(regs.out_min)) begin
			clamped = regs.out_min;
		end else if (sum > RW'(regs.out_max)) begin
			clamped = regs.out_max;
		end else begin
			clamped = sum[BB-1:0];
		end
		if (regs.mode[rcpwm_pkg::MODE_DEAD_BIT] && clamped > regs.dead_low
				&& clamped < regs.dead_high) begin
			res_d = regs.dead_value;
		end else begin
			res_d = clamped;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fix) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_width_q <= width_q;
			out_sat_q   <= sat_q;
			if (regs.mode[rcpwm_pkg::MODE_MAP_BIT]) begin
				out_value_q <= VALUE_BITS'(res_q);
			end else begin
				out_value_q <= $signed({1'b0, (VALUE_BITS-1)'(width_q)});
			end
		end
	end

	assign results.valid           = out_valid_q;
	assign results.value           = out_value_q;
	assign results.pulse_width     = out_width_q;
	assign results.width_saturated = out_sat_q;

	assign status.map_en   = regs.mode[rcpwm_pkg::MODE_MAP_BIT];
	assign status.div_done = (cnt_q == '0);
	assign status.out_free = !out_valid_q || results.ready;

endmodule

>>> design/rc_pulse_width_mapper_top.sv
// RC pulse-width mapper.
// edges: one item per pin edge (pin_level, timestamp_us). A rising edge stores
// its timestamp and yields no result; a falling edge yields one item on results
// with the saturated high time, a saturation flag and the value (mapped, or raw width).
// cfg: register writes (index, data), always ready; write only while idle.
// Rising edge: edges.ready stays high after it is accepted.
// Falling edge, mapping off: the block goes straight to its done state and loads
// the result once the output register is free; then the next edge can be taken.
// Falling edge, mapping on: the block steps through its multiply, setup, divide,
// fix and done states in that order; the divide state forms a P-bit quotient, where
// P = max(WIDTH_BITS, 16) + 18 is the bit count of the restoring divider that
// runs one quotient bit per cycle (P = 34 at defaults).
// edges.ready is low from a falling edge until its result is in the output
// register; one item is in work at a time.
// A result waits in the output register while results.ready is low; the
// next edge is still taken, and a further result stalls until the register
// frees.
// Reset clears the stored rise time to zero, restores register defaults and
// drops any pending result.
`timescale 1ns / 1ps

module rc_pulse_width_mapper_top #(
	parameter int TIMESTAMP_BITS = 32,
	parameter int WIDTH_BITS     = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	rcpwm_edge_if.sink     edges,
	rcpwm_result_if.source results,
	rcpwm_cfg_if.sink      cfg
);

	localparam int VALUE_BITS = (WIDTH_BITS + 1 > 17) ? WIDTH_BITS + 1 : 17;

	rcpwm_pkg::cfg_regs_t regs;
	rcpwm_pkg::cmd_t      cmd;
	rcpwm_pkg::status_t   status;

	rcpwm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	rcpwm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (edges.valid),
		.in_pin_level (edges.pin_level),
		.in_ready     (edges.ready),
		.status       (status),
		.cmd          (cmd)
	);

	rcpwm_dp #(
		.TIMESTAMP_BITS (TIMESTAMP_BITS),
		.WIDTH_BITS     (WIDTH_BITS),
		.VALUE_BITS     (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.timestamp_us (edges.timestamp_us),
		.regs         (regs),
		.cmd          (cmd),
		.status       (status),
		.results      (results)
	);

endmodule

>>> design/rcpwm_checker.sv
`timescale 1ns / 1ps

module rcpwm_checker #(
	parameter int WIDTH_BITS = 16,
	parameter int VALUE_BITS = 17
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_pin_level,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] out_value,
	input logic [WIDTH_BITS-1:0] out_pulse_width,
	input logic                  out_width_saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_pulse_width) && $stable(out_width_saturated))
		else $error("result changed while stalled");

	a_fall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_pin_level |=> !in_ready)
		else $error("falling edge did not occupy the block");

	a_rise_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_pin_level |=> in_ready)
		else $error("rising edge blocked the next item");

	a_sat_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_width_saturated |-> out_pulse_width == '1)
		else $error("saturated width is not full scale");

endmodule

bind rc_pulse_width_mapper_top rcpwm_checker #(
	.WIDTH_BITS (WIDTH_BITS),
	.VALUE_BITS (VALUE_BITS)
) u_rcpwm_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (edges.valid),
	.in_ready            (edges.ready),
	.in_pin_level        (edges.pin_level),
	.out_valid           (results.valid),
	.out_ready           (results.ready),
	.out_value           (results.value),
	.out_pulse_width     (results.pulse_width),
	.out_width_saturated (results.width_saturated)
);
